FILE: src/bracket_balance_checker_top_assert.svh
// Assertion macros used by the bracket balance checker's port-level checker.
`ifndef BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define BBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bracket balance checker: assertion failed");

// Check cons in the cycle after ante holds.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bracket balance checker: assertion failed");

`endif

FILE: src/bbc_pkg.sv
// Shared types and constants of the bracket balance checker.
package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int POS_W       = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [POS_W-1:0] POS_MAX  = '1;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAREN = 2'd0;
  localparam kind_t KIND_BRACE = 2'd1;
  localparam kind_t KIND_BRACK = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXTRA    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] pos;
  } entry_t;

  // Shift commands broadcast to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

FILE: src/bracket_balance_checker_top.sv
// Top level of the bracket balance checker: scanner, stack cell row, result register.
//
// Checks ( ) { } [ ] nesting in a text streamed one byte per transaction,
// with is_last on the final byte. Text between single quotes is skipped and
// a backslash inside quotes skips the next byte. The stack is a row of 64
// cells that shift as a whole toward the bottom on a push and toward the
// top on a pop, so the top opener always sits in cell 0; one byte per
// clock is taken whenever the text channel does not stall. The
// result of a text (status and 1-based error_position, 0 when ok) appears
// on the result channel the cycle after its last byte is taken. Only the
// first error of a text is kept; unclosed reports the innermost open
// bracket. The text channel stalls only when a last byte arrives while an
// earlier result still sits stalled in the result register. All scan state
// clears after each last byte, so texts follow one another back to back.
module bracket_balance_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        is_last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [15:0] error_position
);

  logic                        fire;
  bbc_pkg::stk_ctl_t           ctl;
  bbc_pkg::entry_t             new_entry;
  bbc_pkg::entry_t             entries [bbc_pkg::STACK_DEPTH];
  bbc_pkg::status_t            res_status;
  logic [bbc_pkg::POS_W-1:0]   res_pos;

  // Hold only a last byte while the result register is full and stalled.
  assign text_stall = result_valid && result_stall && is_last;
  assign fire       = text_valid && !text_stall;

  bbc_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .text_byte    (text_byte),
    .is_last      (is_last),
    .top_entry    (entries[0]),
    .second_entry (entries[1]),
    .ctl          (ctl),
    .new_entry    (new_entry),
    .res_status   (res_status),
    .res_pos      (res_pos)
  );

  // Stack row: cell 0 is the top; push feeds it the new opener.
  for (genvar i = 0; i < bbc_pkg::STACK_DEPTH; i++) begin : g_cell
    if (i == 0 && bbc_pkg::STACK_DEPTH > 1) begin : g_top
      bbc_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .from_above (new_entry),
        .from_below (entries[i+1]),
        .entry      (entries[i])
      );
    end else if (i == bbc_pkg::STACK_DEPTH - 1) begin : g_bottom
      bbc_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .from_above (entries[i-1]),
        .from_below (entries[i]),
        .entry      (entries[i])
      );
    end else begin : g_mid
      bbc_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .from_above (entries[i-1]),
        .from_below (entries[i+1]),
        .entry      (entries[i])
      );
    end
  end

  // Result register: load on a last byte, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && is_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_last) begin
      status         <= 3'(res_status);
      error_position <= 16'(res_pos);
    end
  end

endmodule

FILE: src/bbc_cell.sv
// One stack cell: shift toward the bottom on push, toward the top on pop.
module bbc_cell (
  input  logic               clk,
  input  bbc_pkg::stk_ctl_t  ctl,
  input  bbc_pkg::entry_t    from_above,
  input  bbc_pkg::entry_t    from_below,
  output bbc_pkg::entry_t    entry
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry <= from_above;
    end else if (ctl.pop) begin
      entry <= from_below;
    end
  end

endmodule

FILE: src/bbc_scan.sv
// Scanner: quote tracking, position count, stack depth and first-error latch.
module bbc_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [7:0]                  text_byte,
  input  logic                        is_last,
  input  bbc_pkg::entry_t             top_entry,
  input  bbc_pkg::entry_t             second_entry,
  output bbc_pkg::stk_ctl_t           ctl,
  output bbc_pkg::entry_t             new_entry,
  output bbc_pkg::status_t            res_status,
  output logic [bbc_pkg::POS_W-1:0]   res_pos
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_QUOTE  = 3'b010,
    MODE_ESCAPE = 3'b100
  } mode_t;

  mode_t                       mode, mode_next;
  logic [bbc_pkg::CNT_W-1:0]   count, count_next;
  logic [bbc_pkg::POS_W-1:0]   char_position, pos_inc;
  bbc_pkg::status_t            latched_status, latched_status_next;
  logic [bbc_pkg::POS_W-1:0]   latched_position, latched_position_next;
  logic                        open_hit, close_hit, act;
  bbc_pkg::kind_t              kind;
  logic [bbc_pkg::POS_W-1:0]   top_pos_after;

  always_comb begin
    open_hit  = 1'b0;
    close_hit = 1'b0;
    kind      = bbc_pkg::KIND_PAREN;
    case (text_byte)
      bbc_pkg::CH_LPAREN: begin open_hit  = 1'b1; kind = bbc_pkg::KIND_PAREN; end
      bbc_pkg::CH_LBRACE: begin open_hit  = 1'b1; kind = bbc_pkg::KIND_BRACE; end
      bbc_pkg::CH_LBRACK: begin open_hit  = 1'b1; kind = bbc_pkg::KIND_BRACK; end
      bbc_pkg::CH_RPAREN: begin close_hit = 1'b1; kind = bbc_pkg::KIND_PAREN; end
      bbc_pkg::CH_RBRACE: begin close_hit = 1'b1; kind = bbc_pkg::KIND_BRACE; end
      bbc_pkg::CH_RBRACK: begin close_hit = 1'b1; kind = bbc_pkg::KIND_BRACK; end
      default: ;
    endcase
  end

  // Saturating 1-based position of the current byte.
  assign pos_inc = (char_position == bbc_pkg::POS_MAX) ? bbc_pkg::POS_MAX
                 : char_position + bbc_pkg::POS_W'(1);

  always_comb begin
    case (mode)
      MODE_ESCAPE: mode_next = MODE_QUOTE;
      MODE_QUOTE: begin
        if (text_byte == bbc_pkg::CH_BSLASH) begin
          mode_next = MODE_ESCAPE;
        end else if (text_byte == bbc_pkg::CH_QUOTE) begin
          mode_next = MODE_NORMAL;
        end else begin
          mode_next = MODE_QUOTE;
        end
      end
      MODE_NORMAL: begin
        mode_next = (text_byte == bbc_pkg::CH_QUOTE) ? MODE_QUOTE : MODE_NORMAL;
      end
      default: mode_next = MODE_NORMAL;
    endcase
  end

  // Brackets count only outside quotes and until the first error.
  assign act = (mode == MODE_NORMAL) && (text_byte != bbc_pkg::CH_QUOTE)
            && (latched_status == bbc_pkg::ST_OK);

  assign ctl.push = fire && act && open_hit && (count != bbc_pkg::CNT_FULL);
  assign ctl.pop  = fire && act && close_hit && (count != '0);

  assign new_entry.kind = kind;
  assign new_entry.pos  = pos_inc;

  always_comb begin
    latched_status_next   = latched_status;
    latched_position_next = latched_position;
    if (fire && act && open_hit && (count == bbc_pkg::CNT_FULL)) begin
      latched_status_next   = bbc_pkg::ST_OVERFLOW;
      latched_position_next = pos_inc;
    end else if (fire && act && close_hit && (count == '0)) begin
      latched_status_next   = bbc_pkg::ST_EXTRA;
      latched_position_next = pos_inc;
    end else if (ctl.pop && (top_entry.kind != kind)) begin
      latched_status_next   = bbc_pkg::ST_MISMATCH;
      latched_position_next = pos_inc;
    end
  end

  always_comb begin
    if (ctl.push) begin
      count_next    = count + bbc_pkg::CNT_W'(1);
      top_pos_after = pos_inc;
    end else if (ctl.pop) begin
      count_next    = count - bbc_pkg::CNT_W'(1);
      top_pos_after = second_entry.pos;
    end else begin
      count_next    = count;
      top_pos_after = top_entry.pos;
    end
  end

  // Outcome of the text if this byte is its last.
  always_comb begin
    if (latched_status_next != bbc_pkg::ST_OK) begin
      res_status = latched_status_next;
      res_pos    = latched_position_next;
    end else if (count_next != '0) begin
      res_status = bbc_pkg::ST_UNCLOSED;
      res_pos    = top_pos_after;
    end else begin
      res_status = bbc_pkg::ST_OK;
      res_pos    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && is_last)) begin
      mode             <= MODE_NORMAL;
      count            <= '0;
      char_position    <= '0;
      latched_status   <= bbc_pkg::ST_OK;
      latched_position <= '0;
    end else if (fire) begin
      mode             <= mode_next;
      count            <= count_next;
      char_position    <= pos_inc;
      latched_status   <= latched_status_next;
      latched_position <= latched_position_next;
    end
  end

endmodule

FILE: src/bbc_checker.sv
// Port-level checker for the bracket balance checker, bound to its top level.
`include "bracket_balance_checker_top_assert.svh"

module bbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        text_valid,
  input logic        text_stall,
  input logic        is_last,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  status,
  input logic [15:0] error_position
);

  `BBC_ASSERT_NOW(a_rise_after_last, $rose(result_valid), $past(text_valid && !text_stall && is_last))
  `BBC_ASSERT_NEXT(a_last_gives_result, text_valid && !text_stall && is_last, result_valid)
  `BBC_ASSERT_NOW(a_ok_zero_pos, result_valid && (status == 3'(bbc_pkg::ST_OK)), error_position == '0)
  `BBC_ASSERT_NOW(a_err_has_pos, result_valid && (status != 3'(bbc_pkg::ST_OK)), error_position != '0)
  `BBC_ASSERT_NEXT(a_stalled_holds, result_valid && result_stall, result_valid && $stable(status) && $stable(error_position))

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
  .clk            (clk),
  .rst            (rst),
  .text_valid     (text_valid),
  .text_stall     (text_stall),
  .is_last        (is_last),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .status         (status),
  .error_position (error_position)
);

FILE: verif/bracket_balance_checker_top_tb.sv
// Self-checking testbench for the bracket balance checker, with directed and random texts.
module bracket_balance_checker_top_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic [1:0] {
    SCAN_PLAIN,
    SCAN_QUOTED,
    SCAN_ESCAPED
  } scan_t;

  typedef struct packed {
    bbc_pkg::status_t          st;
    logic [bbc_pkg::POS_W-1:0] pos;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        text_valid;
  logic        text_stall;
  logic [7:0]  text_byte;
  logic        is_last;
  logic        result_valid;
  logic        result_stall;
  logic [2:0]  status;
  logic [15:0] error_position;

  // Predicted scanner state, kept in step with every accepted byte.
  scan_t                     scan_state    = SCAN_PLAIN;
  bbc_pkg::kind_t            open_kind_mem [bbc_pkg::STACK_DEPTH];
  logic [bbc_pkg::POS_W-1:0] open_pos_mem  [bbc_pkg::STACK_DEPTH];
  int                        open_depth    = 0;
  logic [bbc_pkg::POS_W-1:0] byte_pos      = '0;
  bbc_pkg::status_t          first_err     = bbc_pkg::ST_OK;
  logic [bbc_pkg::POS_W-1:0] first_err_pos = '0;

  verdict_t    verdict_q[$];      // verdicts still owed by the block, oldest first
  logic [7:0]  text_buf[$];       // text about to be streamed
  int          bytes_sent   = 0;
  int          fail_count   = 0;
  int          hold_request = 0;  // set by the tests, consumed by the result-side process
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;

  bracket_balance_checker_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .text_valid     (text_valid),
    .text_stall     (text_stall),
    .text_byte      (text_byte),
    .is_last        (is_last),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .error_position (error_position)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bracket decoding for the predictor
  // ---------------------------------------------------------------------------
  function automatic bit decode_open(input logic [7:0] b, output bbc_pkg::kind_t k);
    k = bbc_pkg::KIND_PAREN;
    case (b)
      bbc_pkg::CH_LPAREN: begin k = bbc_pkg::KIND_PAREN; return 1'b1; end
      bbc_pkg::CH_LBRACE: begin k = bbc_pkg::KIND_BRACE; return 1'b1; end
      bbc_pkg::CH_LBRACK: begin k = bbc_pkg::KIND_BRACK; return 1'b1; end
      default:            return 1'b0;
    endcase
  endfunction

  function automatic bit decode_close(input logic [7:0] b, output bbc_pkg::kind_t k);
    k = bbc_pkg::KIND_PAREN;
    case (b)
      bbc_pkg::CH_RPAREN: begin k = bbc_pkg::KIND_PAREN; return 1'b1; end
      bbc_pkg::CH_RBRACE: begin k = bbc_pkg::KIND_BRACE; return 1'b1; end
      bbc_pkg::CH_RBRACK: begin k = bbc_pkg::KIND_BRACK; return 1'b1; end
      default:            return 1'b0;
    endcase
  endfunction

  // Advance the predicted scanner by one accepted byte; queue a verdict on the last one.
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    bbc_pkg::kind_t k;
    verdict_t       v;
    if (byte_pos != bbc_pkg::POS_MAX) byte_pos++;
    case (scan_state)
      SCAN_ESCAPED: scan_state = SCAN_QUOTED;
      SCAN_QUOTED: begin
        if (b == bbc_pkg::CH_BSLASH) scan_state = SCAN_ESCAPED;
        else if (b == bbc_pkg::CH_QUOTE) scan_state = SCAN_PLAIN;
      end
      default: begin
        if (b == bbc_pkg::CH_QUOTE) begin
          scan_state = SCAN_QUOTED;
        end else if (first_err == bbc_pkg::ST_OK) begin
          if (decode_open(b, k)) begin
            if (open_depth == bbc_pkg::STACK_DEPTH) begin
              first_err     = bbc_pkg::ST_OVERFLOW;
              first_err_pos = byte_pos;
            end else begin
              open_kind_mem[open_depth] = k;
              open_pos_mem[open_depth]  = byte_pos;
              open_depth++;
            end
          end else if (decode_close(b, k)) begin
            if (open_depth == 0) begin
              first_err     = bbc_pkg::ST_EXTRA;
              first_err_pos = byte_pos;
            end else begin
              open_depth--;
              if (open_kind_mem[open_depth] != k) begin
                first_err     = bbc_pkg::ST_MISMATCH;
                first_err_pos = byte_pos;
              end
            end
          end
        end
      end
    endcase
    if (last) begin
      v.st  = bbc_pkg::ST_OK;
      v.pos = '0;
      if (first_err != bbc_pkg::ST_OK) begin
        v.st  = first_err;
        v.pos = first_err_pos;
      end else if (open_depth > 0) begin
        v.st  = bbc_pkg::ST_UNCLOSED;
        v.pos = open_pos_mem[open_depth-1];
      end
      verdict_q.push_back(v);
      // An open quote is dropped silently; everything clears for the next text.
      scan_state    = SCAN_PLAIN;
      open_depth    = 0;
      byte_pos      = '0;
      first_err     = bbc_pkg::ST_OK;
      first_err_pos = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall in random bursts or for a long hold, and check each transaction
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int n;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && result_valid && !result_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual status %0d position %0d",
                 $time, status, error_position);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (status !== want.st) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, want.st, status);
          fail_count++;
        end
        if (error_position !== want.pos) begin
          $display("%0t error_position mismatch: expected %0d actual %0d",
                   $time, want.pos, error_position);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Text side
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the block takes the transaction, then predict.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    is_last    <= last;
    do @(posedge clk); while (text_stall);
    bytes_sent++;
    predict_byte(b, last);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // Drop valid and wait until every owed verdict has arrived.
  task automatic drain_results();
    text_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] open_char(input bbc_pkg::kind_t k);
    case (k)
      bbc_pkg::KIND_BRACE: return bbc_pkg::CH_LBRACE;
      bbc_pkg::KIND_BRACK: return bbc_pkg::CH_LBRACK;
      default:             return bbc_pkg::CH_LPAREN;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input bbc_pkg::kind_t k);
    case (k)
      bbc_pkg::KIND_BRACE: return bbc_pkg::CH_RBRACE;
      bbc_pkg::KIND_BRACK: return bbc_pkg::CH_RBRACK;
      default:             return bbc_pkg::CH_RPAREN;
    endcase
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 7))
      0:       return bbc_pkg::CH_LPAREN;
      1:       return bbc_pkg::CH_RPAREN;
      2:       return bbc_pkg::CH_LBRACE;
      3:       return bbc_pkg::CH_RBRACE;
      4:       return bbc_pkg::CH_LBRACK;
      5:       return bbc_pkg::CH_RBRACK;
      6:       return bbc_pkg::CH_QUOTE;
      default: return bbc_pkg::CH_BSLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Fill text_buf: mostly well-nested texts with quotes and letters, some corrupted,
  // the rest raw noise over all byte values.
  task automatic build_random_text();
    bbc_pkg::kind_t opens[$];
    bbc_pkg::kind_t k;
    logic [7:0]     ch;
    int unsigned    deep_max;
    int unsigned    r;
    text_buf.delete();
    if ($urandom_range(0, 9) < 7) begin
      deep_max = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 68) : $urandom_range(1, 6);
      // Deep texts start with a run of openers so the stack gets close to full or beyond.
      if (deep_max > 8) begin
        repeat (deep_max) begin
          k = bbc_pkg::kind_t'($urandom_range(0, 2));
          opens.push_back(k);
          text_buf.push_back(open_char(k));
        end
      end
      repeat ($urandom_range(1, 14)) begin
        r = $urandom_range(0, 9);
        if (r < 4 && opens.size() < deep_max) begin
          k = bbc_pkg::kind_t'($urandom_range(0, 2));
          opens.push_back(k);
          text_buf.push_back(open_char(k));
        end else if (r < 7 && opens.size() > 0) begin
          text_buf.push_back(close_char(opens.pop_back()));
        end else if (r == 7) begin
          // Quoted run: brackets inside are skipped, backslash escapes the next byte.
          text_buf.push_back(bbc_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
              text_buf.push_back(bbc_pkg::CH_BSLASH);
              text_buf.push_back($urandom_range(0, 1) ? pick_special() : pick_letter());
            end else begin
              ch = pick_special();
              if (ch == bbc_pkg::CH_QUOTE || ch == bbc_pkg::CH_BSLASH) ch = pick_letter();
              text_buf.push_back(ch);
            end
          end
          if ($urandom_range(0, 7) != 0) text_buf.push_back(bbc_pkg::CH_QUOTE);
        end else begin
          text_buf.push_back(pick_letter());
        end
      end
      if ($urandom_range(0, 4) != 0)
        while (opens.size() > 0) text_buf.push_back(close_char(opens.pop_back()));
      if ($urandom_range(0, 3) == 0)
        text_buf[$urandom_range(0, text_buf.size() - 1)] = pick_special();
    end else begin
      repeat ($urandom_range(1, 20))
        text_buf.push_back($urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_plain_texts();
    send_string("a");
    send_string("{[()]}");
    send_string(")");
    send_string("(]");
    send_string("{)");
    send_string("([{");
    send_string("x(y}z");
    // Extreme byte values carry no bracket meaning.
    text_buf = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_text();
  endtask

  task automatic test_quoting();
    send_string("'(\\')'");     // quoted opener, escaped quote, then quote closes
    send_string("('abc");       // open quote at end, opener still unclosed
    send_string("')");          // closer hidden in an open quote
    send_string("'\\");         // text ends right after a backslash in a quote
    send_string("'x'(]");       // quote closed, mismatch counted past it
  endtask

  task automatic test_first_error_kept();
    send_string(")(((");        // extra closing, later openers leave the stack alone
    send_string("(]]]((");      // mismatch at the first closer only
  endtask

  task automatic test_stack_full();
    text_buf.delete();
    repeat (bbc_pkg::STACK_DEPTH + 1) text_buf.push_back(bbc_pkg::CH_LPAREN);
    send_text();                // opener on a full stack
    text_buf.delete();
    repeat (bbc_pkg::STACK_DEPTH) text_buf.push_back(bbc_pkg::CH_LBRACK);
    text_buf.push_back(bbc_pkg::CH_RBRACK);
    send_text();                // exactly full, then one pop: unclosed
  endtask

  task automatic test_random_texts(input int n_bytes, input bit with_pauses);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_random_text();
      send_text();
      if (with_pauses && $urandom_range(0, 11) == 0) drain_results();
    end
  endtask

  // Block the result side for a long stretch while texts keep coming, so the
  // result register fills and the text side backs up.
  task automatic test_result_hold();
    src_idle_on  = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (15) begin
      build_random_text();
      send_text();
    end
    drain_results();
    src_idle_on = 1'b1;
  endtask

  initial begin
    rst        <= 1'b1;
    text_valid <= 1'b0;
    text_byte  <= 8'h00;
    is_last    <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    test_plain_texts();
    test_quoting();
    test_first_error_kept();
    test_stack_full();
    drain_results();
    test_random_texts(150, 1'b0);
    test_result_hold();
    test_random_texts(100, 1'b1);

    // Close with a stretch at full rate on both sides.
    drain_results();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_texts(60, 1'b0);
    drain_results();
    repeat (5) @(posedge clk);

    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("timeout with %0d verdicts outstanding", verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bbc_pkg.sv
src/bbc_cell.sv
src/bbc_scan.sv
src/bracket_balance_checker_top.sv
src/bbc_checker.sv
verif/bracket_balance_checker_top_tb.sv
